// File: sv/kfc_pkg.sv
// ----------------------------------------------------------------------------
// kfc_pkg
// Shared constants, key codes and controller/datapath interface types for the
// keypad four-function calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package kfc_pkg;

   // Operand width; all operand arithmetic wraps at this width
   localparam int OPERAND_BITS = 32;
   localparam int CNT_BITS     = $clog2(OPERAND_BITS);
   localparam int KEY_BITS     = 8;
   localparam int SHOWN_BITS   = 32;

   // Key codes
   localparam logic [KEY_BITS-1:0] KEY_DIGIT_MAX = 8'd9;
   localparam logic [KEY_BITS-1:0] KEY_CLEAR     = 8'd13;
   localparam logic [KEY_BITS-1:0] KEY_EQUALS    = 8'd61;
   localparam logic [KEY_BITS-1:0] OP_MUL        = 8'd42;
   localparam logic [KEY_BITS-1:0] OP_DIV        = 8'd37;
   localparam logic [KEY_BITS-1:0] OP_ADD        = 8'd43;
   localparam logic [KEY_BITS-1:0] OP_SUB        = 8'd45;

   // Decimal entry multiplier
   localparam int DECIMAL_BASE = 10;

   // Result event kinds
   typedef enum logic [1:0] {
      EV_DIGIT  = 2'd0,
      EV_OPER   = 2'd1,
      EV_RESULT = 2'd2,
      EV_CLEAR  = 2'd3
   } event_kind_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_key;   // capture the key of the accepted transaction
      logic exec;       // decode key, update operands, stage result
      logic div_step;   // one restoring divide iteration
      logic emit;       // move staged result into the output register
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic div_eval;   // '=' with divide and a nonzero divisor
      logic div_last;   // final divide iteration this cycle
      logic slot_free;  // output register can take a result
   } dp_stat_type;

endpackage

`default_nettype wire

// File: sv/kfc_dp.sv
// ----------------------------------------------------------------------------
// kfc_dp
// Calculator datapath: key register, operand registers, pending operator,
// combinational multiply/add/subtract, bit-serial restoring divider and the
// output register of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module kfc_dp (
   input  wire                           clock,
   input  wire                           reset,
   input  kfc_pkg::dp_cmd_type           cmd,
   output kfc_pkg::dp_stat_type          stat,
   input  wire  [kfc_pkg::KEY_BITS-1:0]  key_code,
   output logic                          rsp_tvalid,
   input  wire                           rsp_tready,
   output logic [kfc_pkg::SHOWN_BITS-1:0] shown_value,
   output kfc_pkg::event_kind_type       event_kind,
   output logic                          divide_by_zero
);
   import kfc_pkg::*;

   localparam int W = OPERAND_BITS;

   // Architectural state
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [W-1:0]        opnd_a_ff, opnd_a_in;
   logic [W-1:0]        opnd_b_ff, opnd_b_in;
   logic [KEY_BITS-1:0] oper_ff, oper_in;
   logic                second_ff, second_in;

   // Staged result
   logic [W-1:0]        res_ff, res_in;
   event_kind_type      res_kind_ff, res_kind_in;
   logic                res_dz_ff, res_dz_in;

   // Divider
   logic [W-1:0]        rem_ff, rem_in;
   logic [W-1:0]        quo_ff, quo_in;
   logic [W-1:0]        dvs_ff, dvs_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SHOWN_BITS-1:0]  rsp_value_ff, rsp_value_in;
   event_kind_type         rsp_kind_ff, rsp_kind_in;
   logic                   rsp_dz_ff, rsp_dz_in;

   logic          is_digit, is_clear, is_equals, b_zero;
   logic [W-1:0]  key_ext, entry_val, entry_next, product, eval_val;
   logic          eval_dz;
   logic [W:0]    rem_shift, rem_diff;
   logic          quo_bit;

   // Key classification
   assign is_digit  = (key_ff <= KEY_DIGIT_MAX);
   assign is_clear  = (key_ff == KEY_CLEAR);
   assign is_equals = (key_ff == KEY_EQUALS);
   assign b_zero    = (opnd_b_ff == '0);
   assign key_ext   = W'(key_ff);

   // Decimal entry: x*10 + digit as shift-add
   assign entry_val  = second_ff ? opnd_b_ff : opnd_a_ff;
   assign entry_next = W'((entry_val << 3) + (entry_val << 1) + key_ext);

   assign product = W'(opnd_a_ff * opnd_b_ff);

   // Evaluation of the non-iterative operators
   always_comb begin
      eval_val = '0;
      eval_dz  = 1'b0;
      unique case (oper_ff)
         OP_MUL:  eval_val = product;
         OP_ADD:  eval_val = opnd_a_ff + opnd_b_ff;
         OP_SUB:  eval_val = opnd_a_ff - opnd_b_ff;
         OP_DIV:  eval_dz  = b_zero;
         default: eval_val = '0;
      endcase
   end

   // Restoring divide step
   assign rem_shift = {rem_ff, quo_ff[W-1]};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};
   assign quo_bit   = ~rem_diff[W];

   // Next state
   always_comb begin
      key_in      = key_ff;
      opnd_a_in   = opnd_a_ff;
      opnd_b_in   = opnd_b_ff;
      oper_in     = oper_ff;
      second_in   = second_ff;
      res_in      = res_ff;
      res_kind_in = res_kind_ff;
      res_dz_in   = res_dz_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      dvs_in      = dvs_ff;
      cnt_in      = cnt_ff;

      if (cmd.load_key) begin
         key_in = key_code;
      end

      if (cmd.exec) begin
         res_dz_in = 1'b0;
         priority if (is_digit) begin
            if (second_ff) begin
               opnd_b_in = entry_next;
            end else begin
               opnd_a_in = entry_next;
            end
            res_in      = key_ext;
            res_kind_in = EV_DIGIT;
         end else if (is_clear) begin
            opnd_a_in   = '0;
            opnd_b_in   = '0;
            second_in   = 1'b0;
            res_in      = '0;
            res_kind_in = EV_CLEAR;
         end else if (is_equals) begin
            opnd_a_in   = '0;
            opnd_b_in   = '0;
            second_in   = 1'b0;
            res_in      = eval_val;
            res_dz_in   = eval_dz;
            res_kind_in = EV_RESULT;
            // Divider takes copies; operands are cleared right away
            rem_in      = '0;
            quo_in      = opnd_a_ff;
            dvs_in      = opnd_b_ff;
            cnt_in      = CNT_BITS'(W - 1);
         end else begin
            oper_in     = key_ff;
            second_in   = 1'b1;
            res_in      = key_ext;
            res_kind_in = EV_OPER;
         end
      end

      if (cmd.div_step) begin
         rem_in = quo_bit ? rem_diff[W-1:0] : rem_shift[W-1:0];
         quo_in = {quo_ff[W-2:0], quo_bit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            res_in = {quo_ff[W-2:0], quo_bit};
         end
      end
   end

   // Output register: loads on emit, drains on tready
   always_comb begin
      rsp_value_in = rsp_value_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_dz_in    = rsp_dz_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = SHOWN_BITS'(res_ff);
         rsp_kind_in  = res_kind_ff;
         rsp_dz_in    = res_dz_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         opnd_a_ff    <= '0;
         opnd_b_ff    <= '0;
         oper_ff      <= '0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         opnd_a_ff    <= opnd_a_in;
         opnd_b_ff    <= opnd_b_in;
         oper_ff      <= oper_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      res_ff       <= res_in;
      res_kind_ff  <= res_kind_in;
      res_dz_ff    <= res_dz_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dvs_ff       <= dvs_in;
      cnt_ff       <= cnt_in;
      rsp_value_ff <= rsp_value_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_dz_ff    <= rsp_dz_in;
   end

   // Status to controller
   assign stat.div_eval  = is_equals && (oper_ff == OP_DIV) && !b_zero;
   assign stat.div_last  = (cnt_ff == '0);
   assign stat.slot_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid     = rsp_valid_ff;
   assign shown_value    = rsp_value_ff;
   assign event_kind     = rsp_kind_ff;
   assign divide_by_zero = rsp_dz_ff;

endmodule

`default_nettype wire

// File: sv/kfc_ctrl.sv
// ----------------------------------------------------------------------------
// kfc_ctrl
// Calculator controller: sequences key capture, decode/execute, the divide
// iterations and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kfc_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  kfc_pkg::dp_stat_type  stat,
   output kfc_pkg::dp_cmd_type   cmd
);
   import kfc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DECODE = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_WRITE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_key = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.exec = 1'b1;
            state_in = stat.div_eval ? ST_DIVIDE : ST_WRITE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.emit = stat.slot_free;
            if (stat.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/keypad_four_function_calculator.sv
// ----------------------------------------------------------------------------
// keypad_four_function_calculator
// Key-press driven four-function calculator (multiply, unsigned divide, add,
// subtract) with decimal operand entry.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one key code per transaction; rsp channel returns
//   exactly one event per key: tdata = shown value, tuser = kind and the
//   divide-by-zero flag.
//   After key acceptance each key passes the decode and write states before
//   rsp_tvalid; '=' with divide and a nonzero divisor also passes the divide
//   state of the bit-serial restoring divider (one quotient bit per cycle).
//   One key is processed at a time; req_tready is high only in idle.
//   The next key is accepted while a finished result still sits in the
//   output register; a stalled receiver holds that result and the block
//   waits with the following result staged until the register frees up.
//   Synchronous reset clears both operands, the pending operator, entry
//   position and the output valid; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_four_function_calculator (
   input  wire         clock,
   input  wire         reset,
   // Input channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,    // [7:0] key_code
   // Result channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,    // [31:0] shown_value
   output logic [2:0]  rsp_tuser     // [1:0] event_kind, [2] divide_by_zero
);
   import kfc_pkg::*;

   dp_cmd_type     cmd;
   dp_stat_type    stat;
   event_kind_type event_kind;
   logic           divide_by_zero;

   kfc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   kfc_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .key_code       (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .shown_value    (rsp_tdata),
      .event_kind     (event_kind),
      .divide_by_zero (divide_by_zero)
   );

   // Pack result kind and flag
   assign rsp_tuser = {divide_by_zero, event_kind};

endmodule

`default_nettype wire

// File: sv/kfc_chk.sv
// ----------------------------------------------------------------------------
// kfc_chk
// Port-level checker for the keypad calculator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kfc_chk (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata,
   input wire [2:0]  rsp_tuser
);
   import kfc_pkg::*;

   // Stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // One key in flight: no acceptance in the cycle after one
   a_one_key: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted back to back");

   // Divide-by-zero flag only on a zero result event
   a_dz_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |->
         (rsp_tuser[1:0] == EV_RESULT) && (rsp_tdata == 32'd0))
      else $error("divide-by-zero flag on wrong event");

   // Clear events show zero
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == EV_CLEAR) |-> (rsp_tdata == 32'd0))
      else $error("clear event with nonzero value");

   // Nothing shown right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind keypad_four_function_calculator kfc_chk u_kfc_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
